// ===== rtl/mste_pkg.sv =====
// ----------------------------------------------------------------------------
// mste_pkg
// Types, codes, constants and helper functions of the sigmoid network engine.
// ----------------------------------------------------------------------------
package mste_pkg;

    localparam int MAX_LAYERS  = 4;
    localparam int MAX_NEURONS = 16;
    localparam int SIG_ENTRIES = 256;

    localparam int DATA_W    = 24;
    localparam int IDX_W     = $clog2(MAX_NEURONS);
    localparam int LAYER_W   = $clog2(MAX_LAYERS);
    localparam int WADDR_W   = $clog2((MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS);
    localparam int AADDR_W   = LAYER_W + IDX_W;
    localparam int WIDTH_W   = 5;
    localparam int LC_W      = 3;
    localparam int LR_W      = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier and accumulator widths.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = 60;

    // Sigmoid table geometry: the input range -8..8 in Q16 spans 20 bits.
    localparam int SIG_RANGE_W = 20;
    localparam int SIG_BITS    = $clog2(SIG_ENTRIES);
    localparam int SIG_SHIFT   = SIG_RANGE_W - SIG_BITS;
    localparam int SIG_IDX_W   = SIG_BITS + 1;
    localparam int SIG_W       = 17;

    localparam int ONE_Q16    = 65536;
    localparam int HALF_RANGE = 524288;
    localparam int FULL_RANGE = 1048576;

    localparam logic signed [PROD_W-1:0] SAT_MAX = 60'sd8388607;
    localparam logic signed [PROD_W-1:0] SAT_MIN = -60'sd8388608;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYER_COUNT   = 3'd0,
        CFG_INPUT_WIDTH   = 3'd1,
        CFG_SECOND_WIDTH  = 3'd2,
        CFG_THIRD_WIDTH   = 3'd3,
        CFG_FOURTH_WIDTH  = 3'd4,
        CFG_LEARNING_RATE = 3'd5,
        CFG_OUTPUT_PREACT = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CMD_LOAD_WEIGHT = 2'd0,
        CMD_LOAD_BIAS   = 2'd1,
        CMD_SAMPLE      = 2'd2,
        CMD_TARGET      = 2'd3
    } t_cmd;

    localparam logic KIND_NEURON = 1'b0;
    localparam logic KIND_LOSS   = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_F_INIT, S_F_RD, S_F_MUL, S_F_ACC, S_F_SIG, S_F_S1, S_F_S2, S_F_S3,
        S_O_RD, S_O_EMIT,
        S_L_RD, S_L_MUL, S_L_ACC, S_L_EMIT,
        S_D_RD, S_D_M1, S_D_M2, S_D_M3,
        S_W_RD, S_W_M1, S_W_M2, S_W_M3,
        S_B_M, S_B_U,
        S_G_RD, S_G_MUL, S_G_ACC, S_G_WR
    } t_state;

    typedef logic [SIG_W-1:0] t_sig_table [0:SIG_ENTRIES];

    function automatic logic signed [DATA_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Restoring shift-and-subtract quotient; only evaluated while the sigmoid
    // table is built at elaboration.
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // 1 / (1 + e^-x) for x >= 0 in Q16, with e^-x from a Taylor series of
    // e^-(x/16) that is then squared four times.
    function automatic longint sig_positive(input longint ax);
        longint unsigned f;
        longint unsigned term;
        longint          s;
        longint unsigned den;
        f    = longint'(ax) << 10;
        term = 64'd1 << 30;
        s    = 0;
        for (int k = 0; k < 16; k++) begin
            if ((k % 2) == 0) begin
                s = s + longint'(term);
            end else begin
                s = s - longint'(term);
            end
            term = udiv64((term * f) >> 30, 64'(k + 1));
        end
        if (s < 0) begin
            s = 0;
        end
        for (int k = 0; k < 4; k++) begin
            s = (s * s + (64'sd1 <<< 29)) >>> 30;
        end
        den = (64'd1 << 30) + longint'(s);
        return longint'(udiv64((64'd1 << 46) + (den >> 1), den));
    endfunction

    function automatic t_sig_table build_sig_table();
        t_sig_table t;
        longint     x;
        for (int i = 0; i <= SIG_ENTRIES; i++) begin
            x = (longint'(i) * FULL_RANGE) / SIG_ENTRIES - HALF_RANGE;
            if (x >= 0) begin
                t[i] = SIG_W'(sig_positive(x));
            end else begin
                t[i] = SIG_W'(ONE_Q16 - sig_positive(-x));
            end
        end
        return t;
    endfunction

    localparam t_sig_table SIG_TABLE = build_sig_table();

endpackage

// ===== rtl/mlp_sigmoid_train_engine.sv =====
// ----------------------------------------------------------------------------
// mlp_sigmoid_train_engine
// Online-trained fully connected sigmoid network in signed Q7.16, built
// around one shared multiplier and accumulator under a sequencer.
// ----------------------------------------------------------------------------
// Load beats (weight, bias, non-final sample or target element) are taken
// without leaving the idle state. The final sample beat starts the forward
// pass: per destination neuron the bias is loaded, each source activation is
// read, multiplied by its weight and accumulated, and the sum is looked up in
// the sigmoid table and interpolated; each output neuron is then reported.
// The final target beat starts training: the loss and output gradients, then
// per layer the deltas, the weight and bias updates and the source
// gradients. The single multiplier, which every product passes through in turn,
// and the one read port of each store set the pace. The input is stalled while
// a pass runs, and a result waiting in the output register holds the pass only
// when the next result is ready and the register has not been emptied.
// ----------------------------------------------------------------------------
module mlp_sigmoid_train_engine
    import mste_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_cmd,
    input  logic [LAYER_W-1:0]         i_layer_sel,
    input  logic [IDX_W-1:0]           i_from_index,
    input  logic [IDX_W-1:0]           i_to_index,
    input  logic signed [DATA_W-1:0]   i_value,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_kind,
    output logic [IDX_W-1:0]           o_out_index,
    output logic signed [DATA_W-1:0]   o_out_value,
    output logic                       o_final_res
);

    // Configuration registers.
    logic [LC_W-1:0]    r_layer_count;
    logic [WIDTH_W-1:0] r_width [0:MAX_LAYERS-1];
    logic [LR_W-1:0]    r_lr;
    logic               r_preact;

    // Sequencer.
    t_state             r_state, n_state;
    logic [LAYER_W-1:0] r_l, n_l;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;

    // Shared arithmetic.
    logic signed [PROD_W-1:0]  r_acc, n_acc;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [SIG_W-1:0]          r_t0, n_t0, r_t1, n_t1;
    logic [SIG_RANGE_W-1:0]    r_rem, n_rem;
    logic signed [DATA_W-1:0]  r_g, n_g, r_w, n_w;

    // Small stores.
    logic signed [DATA_W-1:0]  r_tgt   [0:MAX_NEURONS-1];
    logic signed [DATA_W-1:0]  r_bias  [0:MAX_LAYERS-2];
    logic signed [DATA_W-1:0]  r_delta [0:MAX_NEURONS-1];
    logic                      bias_we, delta_we;
    logic [LAYER_W-1:0]        bias_wa;
    logic signed [DATA_W-1:0]  bias_wd, delta_wd;

    // Memories.
    logic signed [DATA_W-1:0]  m_weight [0:(MAX_LAYERS-1)*MAX_NEURONS*MAX_NEURONS-1];
    logic signed [DATA_W-1:0]  m_act    [0:MAX_LAYERS*MAX_NEURONS-1];
    logic signed [DATA_W-1:0]  m_pre    [0:MAX_LAYERS*MAX_NEURONS-1];
    logic signed [DATA_W-1:0]  m_grad   [0:MAX_LAYERS*MAX_NEURONS-1];
    logic [MAX_LAYERS*MAX_NEURONS-1:0] r_act_vld;
    logic signed [DATA_W-1:0]  r_w_rd, r_act_rd, r_pre_rd, r_grad_rd;
    logic                      r_act_rd_vld;

    logic                      w_we, act_we, pre_we, grad_we;
    logic [WADDR_W-1:0]        w_wa, w_ra;
    logic [AADDR_W-1:0]        act_wa, act_ra, pre_wa, pre_ra, grad_wa, grad_ra;
    logic signed [DATA_W-1:0]  w_wd, act_wd, pre_wd, grad_wd;

    // Output register.
    logic                      r_out_valid;
    logic                      r_out_kind;
    logic [IDX_W-1:0]          r_out_index;
    logic signed [DATA_W-1:0]  r_out_value;
    logic                      r_out_final;
    logic                      out_load, out_free;
    logic                      n_out_kind, n_out_final;
    logic [IDX_W-1:0]          n_out_index;
    logic signed [DATA_W-1:0]  n_out_value;

    // Derived values.
    logic [LAYER_W-1:0]        top;
    logic [IDX_W-1:0]          ws_m1, wd_m1, wo_m1;
    logic signed [DATA_W-1:0]  act_q;
    logic signed [DATA_W-1:0]  tgt_q;
    logic signed [DATA_W-1:0]  z;
    logic signed [DATA_W:0]    zu;
    logic signed [DATA_W:0]    diff;
    logic [SIG_IDX_W-1:0]      sig_idx, sig_idx1;
    logic [PROD_W-1:0]         sig_sum;
    logic signed [PROD_W-1:0]  prod_q16;
    logic                      out_last;

    function automatic logic [IDX_W-1:0] width_m1(input logic [WIDTH_W-1:0] w);
        logic [IDX_W-1:0] r;
        if (w == '0) begin
            r = '0;
        end else if (w > WIDTH_W'(MAX_NEURONS)) begin
            r = IDX_W'(MAX_NEURONS - 1);
        end else begin
            r = IDX_W'(w - WIDTH_W'(1));
        end
        return r;
    endfunction

    always_comb begin
        if (r_layer_count < LC_W'(2)) begin
            top = LAYER_W'(1);
        end else if (r_layer_count > LC_W'(MAX_LAYERS)) begin
            top = LAYER_W'(MAX_LAYERS - 1);
        end else begin
            top = LAYER_W'(r_layer_count - LC_W'(1));
        end
    end

    assign ws_m1    = width_m1(r_width[r_l]);
    assign wd_m1    = width_m1(r_width[r_l + LAYER_W'(1)]);
    assign wo_m1    = width_m1(r_width[top]);
    assign act_q    = r_act_rd_vld ? r_act_rd : '0;
    assign tgt_q    = r_tgt[r_j];
    assign prod_q16 = r_prod >>> 16;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_last = (r_j == wo_m1);

    // Sigmoid table index and interpolation weight of the new sum.
    assign z  = sat24(r_acc >>> 16);
    assign zu = (DATA_W+1)'(z) + (DATA_W+1)'(HALF_RANGE);
    assign sig_sum = r_acc + r_prod;
    assign diff    = (DATA_W+1)'(tgt_q) - (DATA_W+1)'(act_q);

    always_comb begin
        if (z <= -DATA_W'(HALF_RANGE)) begin
            sig_idx = '0;
            n_rem   = '0;
        end else if (z >= DATA_W'(HALF_RANGE)) begin
            sig_idx = SIG_IDX_W'(SIG_ENTRIES);
            n_rem   = '0;
        end else begin
            sig_idx = SIG_IDX_W'(zu[SIG_RANGE_W-1:SIG_SHIFT]);
            n_rem   = {zu[SIG_SHIFT-1:0], SIG_BITS'(0)};
        end
        sig_idx1 = (sig_idx == SIG_IDX_W'(SIG_ENTRIES)) ? sig_idx
                                                        : sig_idx + SIG_IDX_W'(1);
        n_t0 = SIG_TABLE[sig_idx];
        n_t1 = SIG_TABLE[sig_idx1];
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_l     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_l     <= n_l;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_l         = r_l;
        n_i         = r_i;
        n_j         = r_j;
        n_acc       = r_acc;
        n_g         = r_g;
        n_w         = r_w;
        mul_a       = '0;
        mul_b       = '0;
        w_we        = 1'b0;
        w_wa        = {r_l, r_i, r_j};
        w_wd        = i_value;
        act_we      = 1'b0;
        act_wa      = {LAYER_W'(0), i_to_index};
        act_wd      = i_value;
        pre_we      = 1'b0;
        pre_wa      = {r_l + LAYER_W'(1), r_j};
        pre_wd      = z;
        grad_we     = 1'b0;
        grad_wa     = {top, r_j};
        grad_wd     = sat24(PROD_W'(act_q) - PROD_W'(tgt_q));
        bias_we     = 1'b0;
        bias_wa     = r_l;
        bias_wd     = i_value;
        delta_we    = 1'b0;
        delta_wd    = sat24(prod_q16);
        out_load    = 1'b0;
        n_out_kind  = KIND_NEURON;
        n_out_index = r_j;
        n_out_value = r_preact ? r_pre_rd : act_q;
        n_out_final = out_last;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_cmd'(i_cmd))
                        CMD_LOAD_WEIGHT: begin
                            w_we = (i_layer_sel != LAYER_W'(MAX_LAYERS - 1));
                            w_wa = {i_layer_sel, i_from_index, i_to_index};
                        end
                        CMD_LOAD_BIAS: begin
                            bias_we = (i_layer_sel != LAYER_W'(MAX_LAYERS - 1));
                            bias_wa = i_layer_sel;
                        end
                        CMD_SAMPLE: begin
                            act_we = 1'b1;
                            if (i_last) begin
                                n_l     = '0;
                                n_j     = '0;
                                n_state = S_F_INIT;
                            end
                        end
                        CMD_TARGET: begin
                            if (i_last) begin
                                n_j     = '0;
                                n_acc   = '0;
                                n_state = S_L_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Forward pass: one destination neuron at a time.
            S_F_INIT: begin
                n_acc   = PROD_W'(r_bias[r_l]) <<< 16;
                n_i     = '0;
                n_state = S_F_RD;
            end
            S_F_RD: n_state = S_F_MUL;
            S_F_MUL: begin
                mul_a   = MUL_A_W'(act_q);
                mul_b   = MUL_B_W'(r_w_rd);
                n_state = S_F_ACC;
            end
            S_F_ACC: begin
                n_acc = r_acc + r_prod;
                if (r_i == ws_m1) begin
                    n_state = S_F_SIG;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_F_RD;
                end
            end
            S_F_SIG: begin
                pre_we  = 1'b1;
                n_state = S_F_S1;
            end
            S_F_S1: begin
                mul_a   = MUL_A_W'(FULL_RANGE) - MUL_A_W'(r_rem);
                mul_b   = MUL_B_W'(r_t0);
                n_state = S_F_S2;
            end
            S_F_S2: begin
                n_acc   = r_prod;
                mul_a   = MUL_A_W'(r_rem);
                mul_b   = MUL_B_W'(r_t1);
                n_state = S_F_S3;
            end
            S_F_S3: begin
                act_we = 1'b1;
                act_wa = {r_l + LAYER_W'(1), r_j};
                act_wd = DATA_W'(sig_sum[SIG_RANGE_W+SIG_W-1:SIG_RANGE_W]);
                if (r_j == wd_m1) begin
                    n_j = '0;
                    if ((r_l + LAYER_W'(1)) == top) begin
                        n_state = S_O_RD;
                    end else begin
                        n_l     = r_l + LAYER_W'(1);
                        n_state = S_F_INIT;
                    end
                end else begin
                    n_j     = r_j + IDX_W'(1);
                    n_state = S_F_INIT;
                end
            end

            // Report the output layer.
            S_O_RD: n_state = S_O_EMIT;
            S_O_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + IDX_W'(1);
                        n_state = S_O_RD;
                    end
                end
            end

            // Loss and output gradients.
            S_L_RD: n_state = S_L_MUL;
            S_L_MUL: begin
                mul_a   = MUL_A_W'(diff);
                mul_b   = MUL_B_W'(diff);
                grad_we = 1'b1;
                n_state = S_L_ACC;
            end
            S_L_ACC: begin
                n_acc = r_acc + r_prod;
                if (out_last) begin
                    n_state = S_L_EMIT;
                end else begin
                    n_j     = r_j + IDX_W'(1);
                    n_state = S_L_RD;
                end
            end
            S_L_EMIT: begin
                n_out_kind  = KIND_LOSS;
                n_out_index = '0;
                n_out_value = sat24(r_acc >>> 17);
                n_out_final = 1'b1;
                if (out_free) begin
                    out_load = 1'b1;
                    n_l      = top - LAYER_W'(1);
                    n_j      = '0;
                    n_state  = S_D_RD;
                end
            end

            // Deltas of the destination layer.
            S_D_RD: n_state = S_D_M1;
            S_D_M1: begin
                mul_a   = MUL_A_W'(act_q);
                mul_b   = MUL_B_W'(ONE_Q16) - MUL_B_W'(act_q);
                n_g     = r_grad_rd;
                n_state = S_D_M2;
            end
            S_D_M2: begin
                mul_a   = MUL_A_W'(prod_q16);
                mul_b   = MUL_B_W'(r_g);
                n_state = S_D_M3;
            end
            S_D_M3: begin
                delta_we = 1'b1;
                if (r_j == wd_m1) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = S_W_RD;
                end else begin
                    n_j     = r_j + IDX_W'(1);
                    n_state = S_D_RD;
                end
            end

            // Weight update, source-major.
            S_W_RD: n_state = S_W_M1;
            S_W_M1: begin
                mul_a   = MUL_A_W'(r_delta[r_j]);
                mul_b   = MUL_B_W'(act_q);
                n_w     = r_w_rd;
                n_state = S_W_M2;
            end
            S_W_M2: begin
                mul_a   = MUL_A_W'(prod_q16);
                mul_b   = MUL_B_W'(r_lr);
                n_state = S_W_M3;
            end
            S_W_M3: begin
                w_we    = 1'b1;
                w_wd    = sat24(PROD_W'(r_w) - prod_q16);
                n_state = S_W_RD;
                if (r_j == wd_m1) begin
                    n_j = '0;
                    if (r_i == ws_m1) begin
                        n_state = S_B_M;
                    end else begin
                        n_i = r_i + IDX_W'(1);
                    end
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end

            // Shared bias, one update per destination neuron.
            S_B_M: begin
                mul_a   = MUL_A_W'(r_delta[r_j]);
                mul_b   = MUL_B_W'(r_lr);
                n_state = S_B_U;
            end
            S_B_U: begin
                bias_we = 1'b1;
                bias_wd = sat24(PROD_W'(r_bias[r_l]) - prod_q16);
                if (r_j == wd_m1) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_acc   = '0;
                    n_state = S_G_RD;
                end else begin
                    n_j     = r_j + IDX_W'(1);
                    n_state = S_B_M;
                end
            end

            // Source gradients from the updated weights.
            S_G_RD: n_state = S_G_MUL;
            S_G_MUL: begin
                mul_a   = MUL_A_W'(r_delta[r_j]);
                mul_b   = MUL_B_W'(r_w_rd);
                n_state = S_G_ACC;
            end
            S_G_ACC: begin
                n_acc = r_acc + r_prod;
                if (r_j == wd_m1) begin
                    n_state = S_G_WR;
                end else begin
                    n_j     = r_j + IDX_W'(1);
                    n_state = S_G_RD;
                end
            end
            S_G_WR: begin
                grad_we = 1'b1;
                grad_wa = {r_l, r_i};
                grad_wd = sat24(r_acc >>> 16);
                n_acc   = '0;
                n_j     = '0;
                if (r_i == ws_m1) begin
                    if (r_l == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_l     = r_l - LAYER_W'(1);
                        n_state = S_D_RD;
                    end
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_G_RD;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            S_F_RD, S_W_RD: act_ra = {r_l, r_i};
            S_D_RD:         act_ra = {r_l + LAYER_W'(1), r_j};
            default:        act_ra = {top, r_j};
        endcase
    end

    assign w_ra    = {r_l, r_i, r_j};
    assign pre_ra  = {top, r_j};
    assign grad_ra = {r_l + LAYER_W'(1), r_j};

    assign o_in_stall = (r_state != S_IDLE);

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        r_g    <= n_g;
        r_w    <= n_w;
        if (r_state == S_F_SIG) begin
            r_t0  <= n_t0;
            r_t1  <= n_t1;
            r_rem <= n_rem;
        end
        if (bias_we) begin
            r_bias[bias_wa] <= bias_wd;
        end
        if (delta_we) begin
            r_delta[r_j] <= delta_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_NEURONS; k++) begin
                r_tgt[k] <= '0;
            end
        end else if (r_state == S_IDLE && i_in_valid && t_cmd'(i_cmd) == CMD_TARGET) begin
            r_tgt[i_to_index] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= LC_W'(3);
            for (int k = 0; k < MAX_LAYERS; k++) begin
                r_width[k] <= WIDTH_W'(MAX_NEURONS);
            end
            r_lr     <= LR_W'(6554);
            r_preact <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_LAYER_COUNT:   r_layer_count <= i_cfg_data[LC_W-1:0];
                CFG_INPUT_WIDTH:   r_width[0]    <= i_cfg_data[WIDTH_W-1:0];
                CFG_SECOND_WIDTH:  r_width[1]    <= i_cfg_data[WIDTH_W-1:0];
                CFG_THIRD_WIDTH:   r_width[2]    <= i_cfg_data[WIDTH_W-1:0];
                CFG_FOURTH_WIDTH:  r_width[3]    <= i_cfg_data[WIDTH_W-1:0];
                CFG_LEARNING_RATE: r_lr          <= i_cfg_data[LR_W-1:0];
                CFG_OUTPUT_PREACT: r_preact      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            m_weight[w_wa] <= w_wd;
        end
        r_w_rd <= m_weight[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (act_we) begin
            m_act[act_wa] <= act_wd;
        end
        r_act_rd <= m_act[act_ra];
    end

    // Activations read as zero until written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_vld    <= '0;
            r_act_rd_vld <= 1'b0;
        end else begin
            if (act_we) begin
                r_act_vld[act_wa] <= 1'b1;
            end
            r_act_rd_vld <= r_act_vld[act_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pre_we) begin
            m_pre[pre_wa] <= pre_wd;
        end
        r_pre_rd <= m_pre[pre_ra];
    end

    always_ff @(posedge i_clk) begin
        if (grad_we) begin
            m_grad[grad_wa] <= grad_wd;
        end
        r_grad_rd <= m_grad[grad_ra];
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind  <= n_out_kind;
            r_out_index <= n_out_index;
            r_out_value <= n_out_value;
            r_out_final <= n_out_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_out_index = r_out_index;
    assign o_out_value = r_out_value;
    assign o_final_res = r_out_final;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_O_EMIT || r_state == S_L_EMIT))
        else $error("result beat raised outside an emit step");

    a_weight_layer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_wa[WADDR_W-1:WADDR_W-LAYER_W] != LAYER_W'(MAX_LAYERS - 1)))
        else $error("weight written to a layer without outgoing weights");

    a_src_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F_ACC || r_state == S_W_M3) |-> (r_i <= ws_m1))
        else $error("source counter ran past the layer width");

endmodule
